// ----- rtl/scr_pkg.sv -----
// Shared types and constants for the sphere collision resolve pipeline.
`default_nettype none

package scr_pkg;

	localparam int AXES     = 3;
	localparam int ROOT_W   = 32;
	localparam int QUO_W    = 32;
	localparam int SQ_W     = 2 * ROOT_W;
	localparam int TERM_W   = SQ_W + 2;

	localparam logic [1:0] KIND_SPHERE   = 2'd0;
	localparam logic [1:0] KIND_BOX      = 2'd1;
	localparam logic [1:0] KIND_OTHER    = 2'd2;
	localparam logic [1:0] KIND_RESERVED = 2'd3;

	typedef struct packed {
		logic [1:0]         pair_kind;
		logic signed [31:0] self_x;
		logic signed [31:0] self_y;
		logic signed [31:0] self_z;
		logic signed [31:0] other_x;
		logic signed [31:0] other_y;
		logic signed [31:0] other_z;
		logic [30:0]        self_radius;
		logic [30:0]        other_radius;
		logic [30:0]        half_x;
		logic [30:0]        half_y;
		logic [30:0]        half_z;
	} scr_in_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] push_x;
		logic signed [31:0] push_y;
		logic signed [31:0] push_z;
	} scr_out_t;

	// Sideband that rides along the square root pipeline
	typedef struct packed {
		logic [1:0]                kind;
		logic                      ss_hit;
		logic                      ss_zero;
		logic [AXES-1:0]           neg;
		logic [31:0]               rsum;
		logic [AXES-1:0][31:0]     mag;
		logic                      box_hit;
		logic [AXES-1:0][31:0]     box_push;
	} scr_side_t;

	// Sideband that rides along the divider pipeline
	typedef struct packed {
		logic [1:0]                kind;
		logic                      ss_hit;
		logic                      ss_zero;
		logic [AXES-1:0]           neg;
		logic                      box_hit;
		logic [AXES-1:0][31:0]     box_push;
	} scr_dside_t;

endpackage

`default_nettype wire

// ----- rtl/sphere_collision_resolve.sv -----
// Top level: sphere-sphere and sphere-box collision test with resolve vector.
//
//  channel | direction | payload   | handshake
//  in      | input     | scr_in_t  | in_valid / in_ready
//  out     | output    | scr_out_t | out_valid / out_ready
//
// One pair per cycle sustained unless the output is held; the path runs through four front
// stages, 32 square root stages (one root bit each), one multiply stage, 32 divider
// stages (one quotient bit each) and the output register.
// The whole pipeline advances as one; it holds only while the output register
// is full and not taken, so in_ready falls exactly then.
// Reset clears the valid bits only; data registers are not reset.
`default_nettype none

module sphere_collision_resolve
	import scr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire scr_in_t  in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output scr_out_t      out_data
);

	logic            en;
	logic            v_f;
	logic [SQ_W-1:0] dsq_f;
	scr_side_t       side_f;
	logic            v_r;
	logic [ROOT_W-1:0] root_r;
	scr_side_t       side_r;
	logic            v_d;
	logic [QUO_W-1:0] quo_d [AXES];
	scr_dside_t      dside_d;
	logic            out_valid_q;
	scr_out_t        out_q;

	// Advance everything unless the output holds a transaction not yet taken
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	scr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_data  (in_data),
		.v_s4     (v_f),
		.dsq_s4   (dsq_f),
		.side_s4  (side_f)
	);

	scr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_f),
		.x_in     (dsq_f),
		.side_in  (side_f),
		.v_out    (v_r),
		.root_out (root_r),
		.side_out (side_r)
	);

	scr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.v_in      (v_r),
		.root_in   (root_r),
		.side_in   (side_r),
		.v_out     (v_d),
		.quo_out   (quo_d),
		.dside_out (dside_d)
	);

	// Sign, saturate and select the resolve vector
	logic [31:0] push_c [AXES];
	logic        hit_c;
	logic        ss_c;
	logic        box_c;

	always_comb begin
		ss_c  = (dside_d.kind == KIND_SPHERE) && dside_d.ss_hit;
		box_c = (dside_d.kind == KIND_BOX) && dside_d.box_hit;
		hit_c = ss_c || box_c;
		for (int a = 0; a < AXES; a++) begin
			if (ss_c && !dside_d.ss_zero) begin
				if (dside_d.neg[a]) begin
					push_c[a] = quo_d[a][31] ? 32'h8000_0000 : (~quo_d[a] + 32'd1);
				end else begin
					push_c[a] = quo_d[a][31] ? 32'h7FFF_FFFF : quo_d[a];
				end
			end else if (box_c) begin
				push_c[a] = dside_d.box_push[a];
			end else begin
				push_c[a] = 32'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.hit    <= hit_c;
			out_q.push_x <= push_c[0];
			out_q.push_y <= push_c[1];
			out_q.push_z <= push_c[2];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A miss never carries a push
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.hit |->
			out_q.push_x == 32'sd0 && out_q.push_y == 32'sd0 && out_q.push_z == 32'sd0)
		else $error("miss with nonzero push");

	// The pipeline stalls only on output backpressure
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid_q && !out_ready)
		else $error("stall without backpressure");

	// A box hit pushes along exactly one axis
	a_box_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		v_d && box_c |->
			$onehot({push_c[0] != 32'd0, push_c[1] != 32'd0, push_c[2] != 32'd0}))
		else $error("box push not on a single axis");

	// While the output register stalls, the divider output and its valid bit hold still
	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(dside_d) && $stable(v_d))
		else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ----- rtl/scr_front.sv -----
// Front stages: center differences, squares, sphere test and box resolve.
`default_nettype none

module scr_front
	import scr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_valid,
	input  wire scr_in_t   in_data,
	output logic           v_s4,
	output logic [SQ_W-1:0] dsq_s4,
	output scr_side_t      side_s4
);

	logic [31:0] self_c  [AXES];
	logic [31:0] other_c [AXES];
	logic [30:0] half_c  [AXES];

	always_comb begin
		self_c[0]  = in_data.self_x;
		self_c[1]  = in_data.self_y;
		self_c[2]  = in_data.self_z;
		other_c[0] = in_data.other_x;
		other_c[1] = in_data.other_y;
		other_c[2] = in_data.other_z;
		half_c[0]  = in_data.half_x;
		half_c[1]  = in_data.half_y;
		half_c[2]  = in_data.half_z;
	end

	// Valid bits advance together with the data
	logic v_s1, v_s2, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: differences and radius sum
	logic [32:0] diff_s1 [AXES];
	logic [30:0] half_s1 [AXES];
	logic [31:0] rsum_s1;
	logic [1:0]  kind_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				diff_s1[a] <= {self_c[a][31], self_c[a]} - {other_c[a][31], other_c[a]};
				half_s1[a] <= half_c[a];
			end
			rsum_s1 <= {1'b0, in_data.self_radius} + {1'b0, in_data.other_radius};
			kind_s1 <= in_data.pair_kind;
		end
	end

	// Stage 2: magnitudes and the per-axis reach test
	logic [32:0]     mag_s2  [AXES];
	logic [30:0]     half_s2 [AXES];
	logic [AXES-1:0] neg_s2;
	logic            near_s2;
	logic [31:0]     rsum_s2;
	logic [1:0]      kind_s2;
	logic [32:0]     mag_c   [AXES];
	logic            near_c;

	always_comb begin
		near_c = 1'b1;
		for (int a = 0; a < AXES; a++) begin
			mag_c[a] = diff_s1[a][32] ? (~diff_s1[a] + 33'd1) : diff_s1[a];
			if (mag_c[a] >= {1'b0, rsum_s1}) near_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				mag_s2[a]  <= mag_c[a];
				half_s2[a] <= half_s1[a];
				neg_s2[a]  <= diff_s1[a][32];
			end
			near_s2 <= near_c;
			rsum_s2 <= rsum_s1;
			kind_s2 <= kind_s1;
		end
	end

	// Stage 3: squares and box axis overlaps
	logic [SQ_W-1:0]    sq_s3  [AXES];
	logic [SQ_W-1:0]    rsq_s3;
	logic signed [34:0] ov_s3  [AXES];
	logic [31:0]        mag_s3 [AXES];
	logic [AXES-1:0]    neg_s3;
	logic               near_s3;
	logic [31:0]        rsum_s3;
	logic [1:0]         kind_s3;
	logic [32:0]        mh_c [AXES];

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			mh_c[a] = (mag_s2[a] < {2'b0, half_s2[a]}) ? mag_s2[a] : {2'b0, half_s2[a]};
		end
	end

	// Own radius travels through stage 2 as a separate copy
	logic [30:0] r_s1, r_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= in_data.self_radius;
			r_s2 <= r_s1;
		end
	end

	logic [32:0] mrr_c [AXES];

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			mrr_c[a] = (mag_s2[a] < {2'b0, r_s2}) ? mag_s2[a] : {2'b0, r_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				sq_s3[a]  <= mag_s2[a][31:0] * mag_s2[a][31:0];
				ov_s3[a]  <= $signed({2'b0, mh_c[a]} + {2'b0, mrr_c[a]}
					- {2'b0, mag_s2[a]});
				mag_s3[a] <= mag_s2[a][31:0];
			end
			rsq_s3  <= rsum_s2 * rsum_s2;
			neg_s3  <= neg_s2;
			near_s3 <= near_s2;
			rsum_s3 <= rsum_s2;
			kind_s3 <= kind_s2;
		end
	end

	// Stage 4: squared distance, sphere hit, box axis selection
	logic [TERM_W-1:0] dsq_c;
	logic              box_hit_c;
	logic [1:0]        best_c;
	logic [31:0]       bpush_c;

	always_comb begin
		dsq_c     = {2'b0, sq_s3[0]} + {2'b0, sq_s3[1]} + {2'b0, sq_s3[2]};
		box_hit_c = 1'b1;
		for (int a = 0; a < AXES; a++) begin
			if (ov_s3[a] <= 35'sd0) box_hit_c = 1'b0;
		end
		best_c = 2'd0;
		if (ov_s3[1] < ov_s3[0]) best_c = 2'd1;
		if (ov_s3[2] < ov_s3[best_c]) best_c = 2'd2;
		bpush_c = neg_s3[best_c] ? ov_s3[best_c][31:0] : (~ov_s3[best_c][31:0] + 32'd1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dsq_s4           <= dsq_c[SQ_W-1:0];
			side_s4.kind     <= kind_s3;
			side_s4.ss_hit   <= near_s3 && (dsq_c < {2'b0, rsq_s3});
			side_s4.ss_zero  <= (dsq_c == '0);
			side_s4.neg      <= neg_s3;
			side_s4.rsum     <= rsum_s3;
			side_s4.box_hit  <= box_hit_c;
			for (int a = 0; a < AXES; a++) begin
				side_s4.mag[a]      <= mag_s3[a];
				side_s4.box_push[a] <= (best_c == 2'(a)) ? bpush_c : 32'd0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/scr_isqrt.sv -----
// Pipelined integer square root, one root bit per stage, with sideband.
`default_nettype none

module scr_isqrt
	import scr_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            v_in,
	input  wire logic [SQ_W-1:0] x_in,
	input  wire scr_side_t       side_in,
	output logic                 v_out,
	output logic [ROOT_W-1:0]    root_out,
	output scr_side_t            side_out
);

	logic              v_s    [1:ROOT_W];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];
	logic [SQ_W-1:0]   rem_s  [1:ROOT_W];
	scr_side_t         side_s [1:ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		localparam int BIT = ROOT_W - 1 - k;

		logic              v_p;
		logic [ROOT_W-1:0] root_p;
		logic [SQ_W-1:0]   rem_p;
		scr_side_t         side_p;
		logic [TERM_W-1:0] term;
		logic              take;

		if (k == 0) begin : g_first
			assign v_p    = v_in;
			assign root_p = '0;
			assign rem_p  = x_in;
			assign side_p = side_in;
		end else begin : g_next
			assign v_p    = v_s[k];
			assign root_p = root_s[k];
			assign rem_p  = rem_s[k];
			assign side_p = side_s[k];
		end

		// Trial: does setting this root bit keep the square at or below x
		always_comb begin
			term = ({{(TERM_W-ROOT_W){1'b0}}, root_p} << (BIT + 1))
				| ({{(TERM_W-1){1'b0}}, 1'b1} << (2 * BIT));
			take = ({2'b0, rem_p} >= term);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_p;
				if (take) begin
					rem_s[k+1]  <= rem_p - term[SQ_W-1:0];
					root_s[k+1] <= root_p | ({{(ROOT_W-1){1'b0}}, 1'b1} << BIT);
				end else begin
					rem_s[k+1]  <= rem_p;
					root_s[k+1] <= root_p;
				end
			end
		end
	end

	assign v_out    = v_s[ROOT_W];
	assign root_out = root_s[ROOT_W];
	assign side_out = side_s[ROOT_W];

endmodule

`default_nettype wire

// ----- rtl/scr_div.sv -----
// Overlap products and a three-lane pipelined restoring divider by the distance.
`default_nettype none

module scr_div
	import scr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              v_in,
	input  wire logic [ROOT_W-1:0] root_in,
	input  wire scr_side_t         side_in,
	output logic                   v_out,
	output logic [QUO_W-1:0]       quo_out [AXES],
	output scr_dside_t             dside_out
);

	// Multiply stage: each magnitude times the overlap
	logic              v_s1;
	logic [63:0]       n_s1 [AXES];
	logic [31:0]       dvs_s1;
	scr_dside_t        dside_s1;
	logic [31:0]       ov_c;

	assign ov_c = side_in.rsum - root_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				n_s1[a] <= side_in.mag[a] * ov_c;
			end
			dvs_s1            <= root_in;
			dside_s1.kind     <= side_in.kind;
			dside_s1.ss_hit   <= side_in.ss_hit;
			dside_s1.ss_zero  <= side_in.ss_zero;
			dside_s1.neg      <= side_in.neg;
			dside_s1.box_hit  <= side_in.box_hit;
			dside_s1.box_push <= side_in.box_push;
		end
	end

	// Divide stages: one quotient bit per stage, shifted into the low word
	logic        v_s    [1:QUO_W];
	logic [31:0] rem_s  [1:QUO_W][AXES];
	logic [31:0] low_s  [1:QUO_W][AXES];
	logic [31:0] dvs_s  [1:QUO_W];
	scr_dside_t  side_s [1:QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic        v_p;
		logic [31:0] rem_p [AXES];
		logic [31:0] low_p [AXES];
		logic [31:0] dvs_p;
		scr_dside_t  side_p;
		logic [32:0] trial [AXES];

		if (k == 0) begin : g_first
			assign v_p    = v_s1;
			assign dvs_p  = dvs_s1;
			assign side_p = dside_s1;
			for (genvar a = 0; a < AXES; a++) begin : g_lane
				assign rem_p[a] = n_s1[a][63:32];
				assign low_p[a] = n_s1[a][31:0];
			end
		end else begin : g_next
			assign v_p    = v_s[k];
			assign dvs_p  = dvs_s[k];
			assign side_p = side_s[k];
			for (genvar a = 0; a < AXES; a++) begin : g_lane
				assign rem_p[a] = rem_s[k][a];
				assign low_p[a] = low_s[k][a];
			end
		end

		always_comb begin
			for (int a = 0; a < AXES; a++) begin
				trial[a] = {rem_p[a], low_p[a][31]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvs_s[k+1]  <= dvs_p;
				side_s[k+1] <= side_p;
				for (int a = 0; a < AXES; a++) begin
					if (trial[a] >= {1'b0, dvs_p}) begin
						rem_s[k+1][a] <= 32'(trial[a] - {1'b0, dvs_p});
						low_s[k+1][a] <= {low_p[a][30:0], 1'b1};
					end else begin
						rem_s[k+1][a] <= trial[a][31:0];
						low_s[k+1][a] <= {low_p[a][30:0], 1'b0};
					end
				end
			end
		end
	end

	assign v_out     = v_s[QUO_W];
	assign dside_out = side_s[QUO_W];

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			quo_out[a] = low_s[QUO_W][a];
		end
	end

endmodule

`default_nettype wire
